// ===== sv/tit_pkg.sv =====
// shared types and constants for the trickle interval timer
`default_nettype none

package tit_pkg;

  localparam int unsigned RAND_W = 32;
  localparam int unsigned STEP_W = $clog2(RAND_W);
  localparam int unsigned IMIN_W = 16;
  localparam int unsigned DBL_W = 4;
  localparam int unsigned RED_W = 8;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PLEN_W = 7;

  localparam logic [IMIN_W-1:0] IMIN_RESET = 16'd1000;
  localparam logic [DBL_W-1:0] DBL_RESET = 4'd8;
  localparam logic [RED_W-1:0] RED_RESET = 8'd2;

  localparam logic [15:0] SHORT_BCAST = 16'hffff;
  localparam logic [63:0] LONG_BCAST = 64'hffff_ffff_ffff_ffff;
  localparam logic [PLEN_W-1:0] MIN_PAYLOAD = 7'd4;
  localparam logic [7:0] HEARD_MAX = 8'd255;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_START = 2'd2
  } tit_req_e;

  typedef enum logic [1:0] {
    DST_NONE  = 2'd0,
    DST_SHORT = 2'd1,
    DST_LONG  = 2'd2
  } tit_addr_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMIN = 2'd0,
    CFG_DBL  = 2'd1,
    CFG_RED  = 2'd2
  } tit_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } tit_state_e;

endpackage

`default_nettype wire

// ===== sv/tit_div.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module tit_div #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tit_pkg::RAND_W-1:0]    dividend_i,
  input  wire logic [TIME_WIDTH-1:0]         divisor_i,
  output logic                               done_o,
  output logic [TIME_WIDTH-1:0]              rem_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [tit_pkg::STEP_W-1:0]  cnt_q, cnt_d;
  logic [tit_pkg::RAND_W-1:0]  dvd_q, dvd_d;
  logic [TIME_WIDTH-1:0]       dsr_q, dsr_d;
  logic [TIME_WIDTH-1:0]       rem_q, rem_d;
  logic [TIME_WIDTH-1:0]       trial;

  assign trial = {rem_q[TIME_WIDTH-2:0], dvd_q[tit_pkg::RAND_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= dsr_q) ? trial - dsr_q : trial;
      dvd_d = {dvd_q[tit_pkg::RAND_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tit_pkg::STEP_W'(tit_pkg::RAND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dsr_q))
    else $error("remainder not below divisor");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done while still busy");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("start while busy");

endmodule

`default_nettype wire

// ===== sv/trickle_interval_timer.sv =====
// trickle dissemination timer top level with sequencer and timer state
//
// channel  direction  handshake               payload
// in       sink       in_valid_i/in_ready_o   req_type, rand_word, dest_mode, short_dest,
//                                             long_dest, payload_len, rx_value
// out      source     out_valid_o/out_ready_i send_now, send_value, value_updated,
//                                             frame_accepted, interval_now
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// an item runs through the exec and final states, with the remainder state between them
// when it starts an interval with a nonzero half; the remainder unit takes 32 steps there
// one item at a time; the next is taken once the result sits in the output register
// a waiting result stalls only the final state; reset clears control state
// config writes are taken every cycle and land in the next item that uses them
`default_nettype none

module trickle_interval_timer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [31:0]                    rand_word_i,
  input  wire logic [1:0]                     dest_mode_i,
  input  wire logic [15:0]                    short_dest_i,
  input  wire logic [63:0]                    long_dest_i,
  input  wire logic [6:0]                     payload_len_i,
  input  wire logic [7:0]                     rx_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                send_now_o,
  output logic [7:0]                          send_value_o,
  output logic                                value_updated_o,
  output logic                                frame_accepted_o,
  output logic [31:0]                         interval_now_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tit_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  tit_pkg::tit_state_e state_q, state_d;

  logic [tit_pkg::IMIN_W-1:0] imin_q;
  logic [tit_pkg::DBL_W-1:0]  dbl_q;
  logic [tit_pkg::RED_W-1:0]  red_q;

  tit_pkg::tit_req_e          req_q;
  logic [31:0]                rnd_q;
  logic                       frame_ok_q;
  logic [7:0]                 rxv_q;

  logic [TIME_WIDTH-1:0] len_q, len_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [TIME_WIDTH-1:0] fire_q, fire_d;
  logic [7:0]            heard_q, heard_d;
  logic [7:0]            own_q, own_d;
  logic                  fire_done_q, fire_done_d;
  logic                  running_q, running_d;
  logic                  send_q, send_d;
  logic                  upd_q, upd_d;
  logic                  acc_q, acc_d;

  logic                  out_valid_q;
  logic                  send_out_q, upd_out_q, acc_out_q;
  logic [7:0]            value_out_q;
  logic [31:0]           interval_out_q;

  logic                  in_acc, out_load, div_start, div_done;
  logic                  begin_w;
  logic [TIME_WIDTH-1:0] new_len, new_half, rem_w;
  logic [TIME_WIDTH-1:0] min_ext, el_inc, dbl_len, cap_len;
  logic [63:0]           cap_wide;
  logic                  bcast;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imin_q <= tit_pkg::IMIN_RESET;
      dbl_q  <= tit_pkg::DBL_RESET;
      red_q  <= tit_pkg::RED_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tit_pkg::CFG_IMIN: imin_q <= cfg_data_i;
        tit_pkg::CFG_DBL:  dbl_q  <= cfg_data_i[tit_pkg::DBL_W-1:0];
        tit_pkg::CFG_RED:  red_q  <= cfg_data_i[tit_pkg::RED_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  assign in_acc = in_valid_i && in_ready_o;
  assign bcast  = ((dest_mode_i == tit_pkg::DST_SHORT)
                   && (short_dest_i == tit_pkg::SHORT_BCAST))
               || ((dest_mode_i == tit_pkg::DST_LONG)
                   && (long_dest_i == tit_pkg::LONG_BCAST));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q      <= tit_pkg::tit_req_e'(req_type_i);
      rnd_q      <= rand_word_i;
      frame_ok_q <= bcast && (payload_len_i >= tit_pkg::MIN_PAYLOAD);
      rxv_q      <= rx_value_i;
    end
  end

  // interval length arithmetic
  assign min_ext  = TIME_WIDTH'(imin_q);
  assign el_inc   = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign cap_wide = 64'(imin_q) << dbl_q;
  assign cap_len  = (cap_wide > 64'(TIME_MAX)) ? TIME_MAX : cap_wide[TIME_WIDTH-1:0];
  assign dbl_len  = len_q[TIME_WIDTH-1] ? TIME_MAX : {len_q[TIME_WIDTH-2:0], 1'b0};

  // item execution
  always_comb begin
    begin_w     = 1'b0;
    new_len     = len_q;
    elapsed_d   = elapsed_q;
    heard_d     = heard_q;
    own_d       = own_q;
    fire_done_d = fire_done_q;
    running_d   = running_q;
    send_d      = send_q;
    upd_d       = upd_q;
    acc_d       = acc_q;
    if (state_q == tit_pkg::ST_EXEC) begin
      send_d = 1'b0;
      upd_d  = 1'b0;
      acc_d  = 1'b0;
      case (req_q)
        tit_pkg::REQ_START: begin
          new_len   = min_ext;
          running_d = 1'b1;
          begin_w   = 1'b1;
        end
        tit_pkg::REQ_TICK: begin
          if (running_q) begin
            elapsed_d = el_inc;
            if (!fire_done_q && (el_inc >= fire_q)) begin
              fire_done_d = 1'b1;
              send_d      = (heard_q < red_q);
            end
            if (el_inc >= len_q) begin
              new_len = (dbl_len > cap_len) ? cap_len : dbl_len;
              begin_w = 1'b1;
            end
          end
        end
        tit_pkg::REQ_FRAME: begin
          if (running_q && frame_ok_q) begin
            acc_d = 1'b1;
            if (rxv_q == own_q) begin
              if (heard_q != tit_pkg::HEARD_MAX) begin
                heard_d = heard_q + 1'b1;
              end
            end else begin
              if (rxv_q > own_q) begin
                own_d = rxv_q;
                upd_d = 1'b1;
              end
              if (len_q > min_ext) begin
                new_len = min_ext;
                begin_w = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      if (begin_w) begin
        heard_d     = '0;
        elapsed_d   = '0;
        fire_done_d = 1'b0;
      end
    end
  end

  assign new_half = new_len >> 1;
  assign len_d    = new_len;

  always_comb begin
    fire_d = fire_q;
    if (state_q == tit_pkg::ST_EXEC && begin_w && (new_half == '0)) begin
      fire_d = '0;
    end else if (state_q == tit_pkg::ST_DIV && div_done) begin
      fire_d = rem_w + (len_q >> 1);
    end
  end

  tit_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rnd_q),
    .divisor_i  (new_half),
    .done_o     (div_done),
    .rem_o      (rem_w)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tit_pkg::ST_IDLE: if (in_valid_i) state_d = tit_pkg::ST_EXEC;
      tit_pkg::ST_EXEC: state_d = (begin_w && (new_half != '0)) ? tit_pkg::ST_DIV
                                                                : tit_pkg::ST_FIN;
      tit_pkg::ST_DIV:  if (div_done) state_d = tit_pkg::ST_FIN;
      tit_pkg::ST_FIN:  if (!out_valid_q || out_ready_i) state_d = tit_pkg::ST_IDLE;
      default:          state_d = tit_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      tit_pkg::ST_IDLE: in_ready_o = 1'b1;
      tit_pkg::ST_EXEC: div_start  = begin_w && (new_half != '0);
      tit_pkg::ST_DIV:  ;
      tit_pkg::ST_FIN:  out_load   = !out_valid_q || out_ready_i;
      default:          ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tit_pkg::ST_IDLE;
      len_q       <= TIME_WIDTH'(tit_pkg::IMIN_RESET);
      elapsed_q   <= '0;
      fire_q      <= '0;
      heard_q     <= '0;
      own_q       <= '0;
      fire_done_q <= 1'b0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      elapsed_q   <= elapsed_d;
      fire_q      <= fire_d;
      heard_q     <= heard_d;
      own_q       <= own_d;
      fire_done_q <= fire_done_d;
      running_q   <= running_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    send_q <= send_d;
    upd_q  <= upd_d;
    acc_q  <= acc_d;
    if (out_load) begin
      send_out_q     <= send_q;
      upd_out_q      <= upd_q;
      acc_out_q      <= acc_q;
      value_out_q    <= own_q;
      interval_out_q <= 32'(len_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign send_now_o       = send_out_q;
  assign send_value_o     = value_out_q;
  assign value_updated_o  = upd_out_q;
  assign frame_accepted_o = acc_out_q;
  assign interval_now_o   = interval_out_q;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == tit_pkg::ST_EXEC))
    else $error("accepted transaction did not enter execution");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tit_pkg::ST_DIV) && div_done |=> (state_q == tit_pkg::ST_FIN))
    else $error("remainder result not consumed");

  a_idle_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> !fire_done_q)
    else $error("fire marked before start");

  a_fire_in_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tit_pkg::ST_IDLE) && running_q |-> (fire_q <= len_q))
    else $error("fire time beyond interval");

endmodule

`default_nettype wire

// ===== test/tb_trickle_interval_timer.sv =====
// self-checking testbench for the trickle interval timer with a cycle-free timer predictor
module tb_trickle_interval_timer;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam logic [1:0] DST_BAD = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] rnd;
    logic [1:0]  mode;
    logic [15:0] sdst;
    logic [63:0] ldst;
    logic [6:0]  plen;
    logic [7:0]  rxv;
  } tit_item_t;

  typedef struct packed {
    logic        send;
    logic [7:0]  value;
    logic        upd;
    logic        acc;
    logic [31:0] interval;
  } tit_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    req_type = '0;
  logic [31:0]                   rand_word = '0;
  logic [1:0]                    dest_mode = '0;
  logic [15:0]                   short_dest = '0;
  logic [63:0]                   long_dest = '0;
  logic [6:0]                    payload_len = '0;
  logic [7:0]                    rx_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          send_now;
  logic [7:0]                    send_value;
  logic                          value_updated;
  logic                          frame_accepted;
  logic [31:0]                   interval_now;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tit_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_data = '0;

  // timer predictor state and its copy of the registers
  logic [15:0] c_imin = tit_pkg::IMIN_RESET;
  logic [3:0]  c_dbl = tit_pkg::DBL_RESET;
  logic [7:0]  c_red = tit_pkg::RED_RESET;
  logic [31:0] tm_len = 32'(tit_pkg::IMIN_RESET);
  logic [31:0] tm_elapsed = '0;
  logic [31:0] tm_fire = '0;
  logic [7:0]  tm_heard = '0;
  logic [7:0]  tm_value = '0;
  logic        tm_fired = 1'b0;
  logic        tm_running = 1'b0;

  tit_item_t   pending_items[$];
  tit_result_t expected_results[$];
  tit_item_t   cur_item;
  tit_result_t got_res;
  tit_result_t want_res;
  logic [7:0]  gen_top = '0;
  bit          calm = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          idle_cycles = 0;
  int          n_fail = 0;

  int ph_imin[6] = '{0, 2, 3, 1, 65535, 5};
  int ph_dbl[6]  = '{0, 3, 15, 4, 15, 2};
  int ph_red[6]  = '{0, 1, 2, 255, 255, 3};
  int ph_len[6]  = '{40, 70, 70, 80, 16, 70};

  trickle_interval_timer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .rand_word_i     (rand_word),
    .dest_mode_i     (dest_mode),
    .short_dest_i    (short_dest),
    .long_dest_i     (long_dest),
    .payload_len_i   (payload_len),
    .rx_value_i      (rx_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .send_now_o      (send_now),
    .send_value_o    (send_value),
    .value_updated_o (value_updated),
    .frame_accepted_o(frame_accepted),
    .interval_now_o  (interval_now),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void open_interval(logic [31:0] rnd);
    logic [31:0] half;
    half = tm_len >> 1;
    tm_heard = '0;
    tm_elapsed = '0;
    tm_fired = 1'b0;
    tm_fire = (half == '0) ? 32'd0 : (rnd % half) + half;
  endfunction

  function automatic tit_result_t predict_step(tit_item_t it);
    tit_result_t r;
    logic [63:0] cap;
    logic [63:0] dbl;
    logic        bcast;
    r = '0;
    case (it.req)
      tit_pkg::REQ_START: begin
        tm_len = {16'b0, c_imin};
        tm_running = 1'b1;
        open_interval(it.rnd);
      end
      tit_pkg::REQ_TICK: begin
        if (tm_running) begin
          if (tm_elapsed != '1) tm_elapsed = tm_elapsed + 32'd1;
          // fire check comes ahead of the interval end
          if (!tm_fired && tm_elapsed >= tm_fire) begin
            tm_fired = 1'b1;
            if (tm_heard < c_red) r.send = 1'b1;
          end
          if (tm_elapsed >= tm_len) begin
            cap = {48'b0, c_imin} << c_dbl;
            if (cap > 64'hffff_ffff) cap = 64'hffff_ffff;
            dbl = (tm_len > 32'h7fff_ffff) ? 64'hffff_ffff : {32'b0, tm_len} << 1;
            tm_len = (dbl > cap) ? cap[31:0] : dbl[31:0];
            open_interval(it.rnd);
          end
        end
      end
      tit_pkg::REQ_FRAME: begin
        if (tm_running) begin
          bcast = (it.mode == tit_pkg::DST_SHORT && it.sdst == tit_pkg::SHORT_BCAST) ||
                  (it.mode == tit_pkg::DST_LONG && it.ldst == tit_pkg::LONG_BCAST);
          if (bcast && it.plen >= tit_pkg::MIN_PAYLOAD) begin
            r.acc = 1'b1;
            if (it.rxv == tm_value) begin
              if (tm_heard != tit_pkg::HEARD_MAX) tm_heard = tm_heard + 8'd1;
            end else begin
              if (it.rxv > tm_value) begin
                tm_value = it.rxv;
                r.upd = 1'b1;
              end
              if (tm_len > {16'b0, c_imin}) begin
                tm_len = {16'b0, c_imin};
                open_interval(it.rnd);
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.value = tm_value;
    r.interval = tm_len;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_fail++;
    end
  endfunction

  function automatic tit_item_t noise_item(logic [1:0] req);
    tit_item_t it;
    it.req = req;
    it.rnd = $urandom;
    it.mode = 2'($urandom_range(3));
    it.sdst = 16'($urandom);
    it.ldst = {$urandom, $urandom};
    it.plen = 7'($urandom_range(127));
    it.rxv = 8'($urandom_range(255));
    return it;
  endfunction

  // frame with the broadcast address of the given address mode, where that mode has one
  function automatic tit_item_t frame_item(logic [1:0] mode, logic [6:0] plen,
                                           logic [7:0] rxv);
    tit_item_t it;
    it = noise_item(tit_pkg::REQ_FRAME);
    it.mode = mode;
    it.plen = plen;
    it.rxv = rxv;
    if (mode == tit_pkg::DST_SHORT) it.sdst = tit_pkg::SHORT_BCAST;
    if (mode == tit_pkg::DST_LONG) it.ldst = tit_pkg::LONG_BCAST;
    return it;
  endfunction

  task automatic queue_item(tit_item_t it);
    if (it.req == tit_pkg::REQ_FRAME && it.plen >= tit_pkg::MIN_PAYLOAD &&
        it.rxv > gen_top &&
        ((it.mode == tit_pkg::DST_SHORT && it.sdst == tit_pkg::SHORT_BCAST) ||
         (it.mode == tit_pkg::DST_LONG && it.ldst == tit_pkg::LONG_BCAST)))
      gen_top = it.rxv;
    pending_items.push_back(it);
  endtask

  function automatic logic [1:0] bcast_mode();
    return $urandom_range(1) ? tit_pkg::DST_SHORT : tit_pkg::DST_LONG;
  endfunction

  task automatic add_random_items(int n);
    int          r;
    int          pick;
    logic [7:0]  v;
    tit_item_t   it;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 3) begin
        it = noise_item(tit_pkg::REQ_START);
      end else if (r < 5) begin
        it = noise_item(REQ_NOP);
      end else if (r < 60) begin
        it = noise_item(tit_pkg::REQ_TICK);
      end else if (r < 90) begin
        pick = $urandom_range(99);
        if (pick < 50) v = gen_top;
        else if (pick < 70) v = (gen_top > 8'd252) ? 8'hff : gen_top + 8'($urandom_range(1, 3));
        else if (pick < 97) v = 8'($urandom_range(gen_top));
        else v = 8'($urandom_range(255));
        it = frame_item(bcast_mode(), 7'($urandom_range(tit_pkg::MIN_PAYLOAD, 127)), v);
      end else if (r < 95) begin
        // broadcast but too short
        it = frame_item(bcast_mode(), 7'($urandom_range(tit_pkg::MIN_PAYLOAD - 1)),
                        8'($urandom_range(255)));
      end else begin
        it = noise_item(tit_pkg::REQ_FRAME);
      end
      queue_item(it);
    end
  endtask

  task automatic write_reg(tit_pkg::tit_cfg_e idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tit_pkg::CFG_IMIN: c_imin = data;
      tit_pkg::CFG_DBL:  c_dbl = data[3:0];
      tit_pkg::CFG_RED:  c_red = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int imin, int dbl, int red);
    logic [15:0] w;
    write_reg(tit_pkg::CFG_IMIN, 16'(imin));
    w = 16'($urandom);
    w[3:0] = 4'(dbl);
    write_reg(tit_pkg::CFG_DBL, w);
    w = 16'($urandom);
    w[7:0] = 8'(red);
    write_reg(tit_pkg::CFG_RED, w);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_step(cur_item));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          req_type <= cur_item.req;
          rand_word <= cur_item.rnd;
          dest_mode <= cur_item.mode;
          short_dest <= cur_item.sdst;
          long_dest <= cur_item.ldst;
          payload_len <= cur_item.plen;
          rx_value <= cur_item.rxv;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(7) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          n_fail++;
        end else begin
          want_res = expected_results.pop_front();
          got_res = {send_now, send_value, value_updated, frame_accepted, interval_now};
          check_field("send_now", 32'(want_res.send), 32'(got_res.send));
          check_field("send_value", 32'(want_res.value), 32'(got_res.value));
          check_field("value_updated", 32'(want_res.upd), 32'(got_res.upd));
          check_field("frame_accepted", 32'(want_res.acc), 32'(got_res.acc));
          check_field("interval_now", want_res.interval, got_res.interval);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(9) == 0) out_stall = $urandom_range(1, 16);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    tit_item_t it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // idle before start, then reset register values
    queue_item(noise_item(tit_pkg::REQ_TICK));
    it = frame_item(tit_pkg::DST_SHORT, 7'd4, 8'd5);
    pending_items.push_back(it);
    queue_item(noise_item(REQ_NOP));
    it = noise_item(tit_pkg::REQ_START);
    it.rnd = 32'hffff_ffff;
    queue_item(it);
    queue_item(noise_item(tit_pkg::REQ_TICK));
    queue_item(frame_item(tit_pkg::DST_SHORT, 7'd127, 8'd0));
    queue_item(frame_item(tit_pkg::DST_LONG, 7'd4, 8'd0));
    it = frame_item(tit_pkg::DST_SHORT, 7'd4, 8'd9);
    it.sdst = 16'hfffe;
    queue_item(it);
    it = frame_item(tit_pkg::DST_LONG, 7'd4, 8'd9);
    it.ldst = 64'hffff_ffff_ffff_fffe;
    queue_item(it);
    it = frame_item(tit_pkg::DST_NONE, 7'd4, 8'd9);
    it.sdst = tit_pkg::SHORT_BCAST;
    it.ldst = tit_pkg::LONG_BCAST;
    queue_item(it);
    it = frame_item(DST_BAD, 7'd4, 8'd9);
    it.sdst = tit_pkg::SHORT_BCAST;
    it.ldst = tit_pkg::LONG_BCAST;
    queue_item(it);
    queue_item(frame_item(tit_pkg::DST_SHORT, 7'd3, 8'd9));
    queue_item(frame_item(tit_pkg::DST_SHORT, 7'd4, 8'd3));
    queue_item(noise_item(REQ_NOP));
    it = noise_item(tit_pkg::REQ_START);
    it.rnd = 32'd0;
    queue_item(it);
    wait_drained();

    // zero half interval, fire and end on one tick, doubling and restart
    set_regs(1, 2, 1);
    queue_item(noise_item(tit_pkg::REQ_START));
    queue_item(noise_item(tit_pkg::REQ_TICK));
    queue_item(noise_item(tit_pkg::REQ_TICK));
    queue_item(frame_item(tit_pkg::DST_LONG, 7'd4, 8'd3));
    repeat (4) queue_item(noise_item(tit_pkg::REQ_TICK));
    queue_item(frame_item(tit_pkg::DST_SHORT, 7'd4, 8'd1));
    queue_item(noise_item(tit_pkg::REQ_TICK));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      set_regs(ph_imin[p], ph_dbl[p], ph_red[p]);
      queue_item(noise_item(tit_pkg::REQ_START));
      add_random_items(ph_len[p]);
      wait_drained();
    end

    // heard counter saturation, no idling from here on
    calm = 1'b1;
    set_regs(4, 1, 255);
    queue_item(noise_item(tit_pkg::REQ_START));
    queue_item(frame_item(tit_pkg::DST_SHORT, 7'd4, 8'd255));
    repeat (260) queue_item(frame_item(bcast_mode(),
                                       7'($urandom_range(tit_pkg::MIN_PAYLOAD, 127)),
                                       8'd255));
    repeat (6) queue_item(noise_item(tit_pkg::REQ_TICK));
    add_random_items(20);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
